// File: src/vlfs_pkg.sv
`timescale 1ns / 1ps

package vlfs_pkg;

    localparam int MAX_VARINT_BYTES = 10;
    localparam int LEN_W            = 64;
    localparam int VALUE_W          = 7;
    localparam int CNT_W            = $clog2(MAX_VARINT_BYTES + 1);

    localparam logic [7:0] CONT_BIT   = 8'b1000_0000;
    localparam logic [7:0] VALUE_BITS = 8'b0111_1111;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_EOS  = 1'b1;

    localparam logic [1:0] PH_LENGTH  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_VARINT    = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_first;
        logic       frame_last;
        logic       empty_frame;
        logic       stream_done;
        logic [1:0] error_code;
    } result_t;

endpackage

// File: src/varint_length_frame_splitter.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Direction  Item
// s_        s_valid/s_ready, s_func, s_data_byte     in         one stream byte or end of stream
// m_        m_valid/m_ready, m_payload_byte, flags   out        payload byte, empty frame or status
// cfg_      cfg_wr_en, cfg_wr_data                   in         skip-first-frame bit, no wait
//
// One item per cycle: each accepted item is decoded in the cycle it is taken and its
// result, if any, lands in the output register at the same edge.
// s_ready is high whenever the output register is empty or being drained this cycle.
// A stalled m_ready holds the output register and blocks intake once a result item waits.
// Reset (synchronous, active low) clears the frame state; skip-first-frame resets to 1.
module varint_length_frame_splitter
    import vlfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_data_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_frame_first,
    output logic       m_frame_last,
    output logic       m_empty_frame,
    output logic       m_stream_done,
    output logic [1:0] m_error_code
);

    logic             skip_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] accum_reg, accum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic             header_seen_reg, header_seen_next;
    logic             at_start_reg, at_start_next;
    logic             dropping_reg, dropping_next;

    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;
    logic             res_valid;

    logic             accept;
    logic [LEN_W-1:0] length_full;
    logic [CNT_W-1:0] count_inc;
    logic             drop_now;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Merge this byte's seven value bits at the position set by the byte count
    always_comb begin
        length_full = accum_reg;
        for (int i = 0; i < MAX_VARINT_BYTES; i++) begin
            if (count_reg == CNT_W'(i)) begin
                length_full = accum_reg
                    | (LEN_W'(s_data_byte & VALUE_BITS) << (VALUE_W * i));
            end
        end
    end

    assign count_inc = count_reg + CNT_W'(1);

    always_comb begin
        phase_next       = phase_reg;
        accum_next       = accum_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        header_seen_next = header_seen_reg;
        at_start_next    = at_start_reg;
        dropping_next    = dropping_reg;
        res              = '0;
        res_valid        = 1'b0;
        drop_now         = 1'b0;

        if (s_func == FUNC_EOS) begin
            res_valid       = 1'b1;
            res.stream_done = 1'b1;
            if (phase_reg == PH_PAYLOAD
                || (phase_reg == PH_LENGTH && count_reg != '0)) begin
                res.error_code = ERR_TRUNCATED;
            end
            phase_next       = PH_LENGTH;
            accum_next       = '0;
            count_next       = '0;
            remain_next      = '0;
            header_seen_next = 1'b0;
            at_start_next    = 1'b1;
            dropping_next    = 1'b0;
        end else begin
            case (phase_reg)
                PH_LENGTH: begin
                    if ((s_data_byte & CONT_BIT) != '0) begin
                        if (count_inc >= CNT_W'(MAX_VARINT_BYTES)) begin
                            phase_next     = PH_ERROR;
                            accum_next     = '0;
                            count_next     = '0;
                            res_valid      = 1'b1;
                            res.error_code = ERR_VARINT;
                        end else begin
                            accum_next = length_full;
                            count_next = count_inc;
                        end
                    end else begin
                        drop_now         = skip_reg && !header_seen_reg;
                        header_seen_next = 1'b1;
                        remain_next      = length_full;
                        accum_next       = '0;
                        count_next       = '0;
                        at_start_next    = 1'b1;
                        if (length_full == '0) begin
                            dropping_next   = 1'b0;
                            res_valid       = !drop_now;
                            res.empty_frame = 1'b1;
                        end else begin
                            dropping_next = drop_now;
                            phase_next    = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    remain_next      = remain_reg - LEN_W'(1);
                    at_start_next    = 1'b0;
                    res.payload_byte = s_data_byte;
                    res.frame_first  = at_start_reg;
                    res.frame_last   = (remain_reg == LEN_W'(1));
                    res_valid        = !dropping_reg;
                    if (remain_reg == LEN_W'(1)) begin
                        phase_next    = PH_LENGTH;
                        at_start_next = 1'b1;
                        dropping_next = 1'b0;
                    end
                end
                default: begin
                    // error phase: data bytes are swallowed until end of stream
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg        <= 1'b1;
            phase_reg       <= PH_LENGTH;
            accum_reg       <= '0;
            count_reg       <= '0;
            remain_reg      <= '0;
            header_seen_reg <= 1'b0;
            at_start_reg    <= 1'b1;
            dropping_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                skip_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg       <= phase_next;
                accum_reg       <= accum_next;
                count_reg       <= count_next;
                remain_reg      <= remain_next;
                header_seen_reg <= header_seen_next;
                at_start_reg    <= at_start_next;
                dropping_reg    <= dropping_next;
                out_valid_reg   <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_frame_first  = out_reg.frame_first;
    assign m_frame_last   = out_reg.frame_last;
    assign m_empty_frame  = out_reg.empty_frame;
    assign m_stream_done  = out_reg.stream_done;
    assign m_error_code   = out_reg.error_code;

endmodule
